[design/ssid_pkg.sv]
// shared types, codes and defaults for the sequence store with indexed delete
// no dependencies; compiled first
package ssid_pkg;

	localparam int SSID_DEPTH = 64;

	// operation codes
	localparam logic [1:0] KIND_FRONT  = 2'd0;
	localparam logic [1:0] KIND_BACK   = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
		logic [5:0]         position;
	} ssid_op_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               is_empty;
		logic [1:0]         status;
		logic               last;
	} ssid_res_t;

	// controller to datapath
	typedef struct packed {
		logic load_op;
		logic apply;
		logic shift_rd;
		logic shift_wr;
		logic shift_done;
		logic dump_rd;
		logic dump_load;
	} ssid_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic del_go;
		logic shift_more;
		logic out_free;
		logic dump_last;
	} ssid_stat_t;

endpackage

[design/ssid_stream_if.sv]
// valid/ready channel carrying one word of a given payload type
// no dependencies
interface ssid_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/ssid_ctrl.sv]
// sequencing state machine: apply, shift for delete, dump
// depends on ssid_pkg
module ssid_ctrl import ssid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output ssid_cmd_t  ctl,
	input  ssid_stat_t stat
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_APPLY    = 6'b000010,
		ST_SHIFT_RD = 6'b000100,
		ST_SHIFT_WR = 6'b001000,
		ST_DUMP_RD  = 6'b010000,
		ST_DUMP_LD  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load_op = 1'b1;
					state_d     = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctl.apply = 1'b1;
				state_d   = stat.del_go ? ST_SHIFT_RD : ST_DUMP_RD;
			end
			ST_SHIFT_RD: begin
				if (stat.shift_more) begin
					ctl.shift_rd = 1'b1;
					state_d      = ST_SHIFT_WR;
				end else begin
					ctl.shift_done = 1'b1;
					state_d        = ST_DUMP_RD;
				end
			end
			ST_SHIFT_WR: begin
				ctl.shift_wr = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_DUMP_RD: begin
				ctl.dump_rd = 1'b1;
				state_d     = ST_DUMP_LD;
			end
			ST_DUMP_LD: begin
				if (stat.out_free) begin
					ctl.dump_load = 1'b1;
					state_d       = stat.dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/ssid_dpath.sv]
// element ring memory, front pointer, count, iterator and output register
// depends on ssid_pkg and ssid_stream_if
module ssid_dpath import ssid_pkg::*; #(
	parameter int DEPTH = SSID_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ssid_cmd_t  ctl,
	output ssid_stat_t stat,
	input  ssid_op_t   op,
	ssid_stream_if.source dump
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_s1;

	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [1:0]       kind_q;
	logic [31:0]      value_q;
	logic [5:0]       pos_q;
	logic [1:0]       status_q;
	ssid_res_t        out_q;
	logic             out_valid_q;

	logic             is_ins;
	logic             full;
	logic [PTR_W-1:0] new_front;
	logic [CNT_W-1:0] rd_idx;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic             wr_en;
	logic             rd_en;

	// ring slot of the i-th element from the front
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] f,
						     input logic [CNT_W-1:0] i);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(f) + (CNT_W+1)'(i);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign is_ins    = (kind_q == KIND_FRONT) || (kind_q == KIND_BACK);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign new_front = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;

	assign rd_idx  = ctl.shift_rd ? idx_q + 1'b1 : idx_q;
	assign rd_addr = slot_of(front_q, rd_idx);
	assign rd_en   = ctl.shift_rd || ctl.dump_rd;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_of(front_q, idx_q);
		wr_data = rdata_s1;
		if (ctl.apply && is_ins && !full) begin
			wr_en   = 1'b1;
			wr_data = value_q;
			wr_addr = (kind_q == KIND_FRONT) ? new_front : slot_of(front_q, count_q);
		end else if (ctl.shift_wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// operation capture
	always_ff @(posedge clk) begin
		if (ctl.load_op) begin
			kind_q  <= op.kind;
			value_q <= op.value;
			pos_q   <= op.position;
		end
	end

	assign stat.del_go     = (kind_q == KIND_DELETE) && (7'(pos_q) < 7'(count_q));
	assign stat.shift_more = (7'(idx_q) + 7'd1) < 7'(count_q);
	assign stat.out_free   = !out_valid_q || dump.ready;
	assign stat.dump_last  = (count_q == '0) || (idx_q + 1'b1 == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (ctl.apply && is_ins && !full) begin
			count_q <= count_q + 1'b1;
			if (kind_q == KIND_FRONT) begin
				front_q <= new_front;
			end
		end else if (ctl.shift_done) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			if (is_ins && full) begin
				status_q <= STATUS_FULL;
			end else if (kind_q == KIND_DELETE && !stat.del_go) begin
				status_q <= STATUS_RANGE;
			end else begin
				status_q <= STATUS_DONE;
			end
			idx_q <= stat.del_go ? CNT_W'(pos_q) : '0;
		end else if (ctl.shift_done) begin
			idx_q <= '0;
		end else if (ctl.shift_wr || ctl.dump_load) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.dump_load) begin
			out_valid_q <= 1'b1;
		end else if (dump.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dump_load) begin
			out_q.element  <= (count_q == '0) ? 32'sd0 : rdata_s1;
			out_q.is_empty <= (count_q == '0);
			out_q.status   <= status_q;
			out_q.last     <= stat.dump_last;
		end
	end

	assign dump.valid   = out_valid_q;
	assign dump.payload = out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		count_q + 1'b1 == $past(count_q))
		else $error("element count moved by more than one");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_empty |-> out_q.last && out_q.element == 32'sd0)
		else $error("empty dump word not final or not zero");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dump_load |-> !out_valid_q || dump.ready)
		else $error("output word overwritten before taken");
`endif

endmodule

[design/sequence_store_with_indexed_delete.sv]
// top level of the sequence store with indexed delete
// depends on ssid_pkg, ssid_stream_if, ssid_ctrl and ssid_dpath
//
// usage
//   cmd  : one word per operation (kind, value, position); kind front inserts
//          at the head, back appends, delete removes the element at position
//   dump : after every operation the whole sequence is sent head to tail, one
//          element per word, last set on the final word; an empty sequence
//          gives one word with is_empty set and element zero
//   status repeats on every word of a dump: done, insert dropped (full) or
//          delete position not below the element count
// timing
//   one operation at a time; cmd.ready is high only between operations
//   per operation: capture and apply; for a delete, each element after the
//   position (count - position - 1 of them) is read and then written one slot
//   toward the head before the loop is left; then each dump word is read and
//   loaded; the memory read is registered, one read port and one write port
//   the next operation is accepted while the final dump word still waits
// reset
//   arst_n clears the count, front pointer, state and output valid; the ring
//   memory is not cleared, only live entries are ever sent on dump
// stall
//   while dump.ready is low the dump word is held and the sequencer waits
module sequence_store_with_indexed_delete import ssid_pkg::*; #(
	parameter int DEPTH = SSID_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	ssid_stream_if.sink   cmd,
	ssid_stream_if.source dump
);

	ssid_cmd_t  ctl;
	ssid_stat_t stat;
	ssid_op_t   op;

	assign op = cmd.payload;

	// sequencer: apply, shift loop for delete, dump loop
	ssid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	// ring memory, pointers and the output word register
	ssid_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.op     (op),
		.dump   (dump)
	);

endmodule
